[rtl/smoothed_histogram_local_threshold_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed histogram local threshold block
// Shared concurrent-check forms, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_HISTOGRAM_LOCAL_THRESHOLD_TOP_MACROS_SVH
`define SMOOTHED_HISTOGRAM_LOCAL_THRESHOLD_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHLT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shlt assertion failed");
`define SHLT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shlt assertion failed");
`else
`define SHLT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SHLT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/shlt_pkg.sv]
// ----------------------------------------------------------------------------
// Smoothed histogram local threshold package
// Types, codes and default sizes shared by the block's modules.
// ----------------------------------------------------------------------------
package shlt_pkg;

   localparam int BINS_DEF       = 256;
   localparam int NEIGHBORS_DEF  = 9;
   localparam int MAX_PASSES_DEF = 64;

   localparam int HIST_W   = 20;
   localparam int WEIGHT_W = 16;
   localparam int LEVEL_W  = 8;
   localparam int OP_W     = 2;
   localparam int ITER_W   = 7;
   localparam int TARGET_W = 17;
   localparam int TOL_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_NBHD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ITER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL    = 2'd2;

   localparam logic [ITER_W-1:0]   ITER_RST   = 7'd20;
   localparam logic [TARGET_W-1:0] TARGET_RST = 17'd32768;
   localparam logic [TOL_W-1:0]    TOL_RST    = 16'd66;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD,
      ST_BUILD_DRAIN,
      ST_MUL_TGT,
      ST_MUL_TOL,
      ST_SWEEP,
      ST_SWEEP_DRAIN,
      ST_CHECK,
      ST_DECIDE,
      ST_MASK_RD,
      ST_MASK_CMP,
      ST_FIN
   } state_type;

endpackage

[rtl/smoothed_histogram_local_threshold_top.sv]
// ----------------------------------------------------------------------------
// Smoothed histogram local threshold
// Weight loading, histogram build, bisection threshold search and masking.
// ----------------------------------------------------------------------------
// A weight load goes straight to the finish state; a pixel request reads the histogram
// and compares before it finishes. A neighborhood request builds the histogram with one
// weight read per bin and neighbor, then runs bisection passes over the histogram RAM.
// One request is in work at a time; a new one is taken while a result waits.
// Synchronous active-high reset clears control state, the threshold and the
// configuration registers; the histogram reads as zero until first built.
`include "smoothed_histogram_local_threshold_top_macros.svh"

module smoothed_histogram_local_threshold_top #(
   parameter int BINS       = shlt_pkg::BINS_DEF,
   parameter int NEIGHBORS  = shlt_pkg::NEIGHBORS_DEF,
   parameter int MAX_PASSES = shlt_pkg::MAX_PASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_nb_0,
   input  logic [7:0]  req_nb_1,
   input  logic [7:0]  req_nb_2,
   input  logic [7:0]  req_nb_3,
   input  logic [7:0]  req_nb_4,
   input  logic [7:0]  req_nb_5,
   input  logic [7:0]  req_nb_6,
   input  logic [7:0]  req_nb_7,
   input  logic [7:0]  req_nb_8,
   input  logic [7:0]  req_level,
   input  logic [15:0] req_weight,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic        rsp_mask_bit,
   output logic [19:0] rsp_threshold,
   output logic [6:0]  rsp_passes,
   output logic        rsp_converged,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int BW  = $clog2(BINS);
   localparam int NKW = $clog2(NEIGHBORS + 1);
   localparam int SW  = shlt_pkg::HIST_W + BW;
   localparam int DW  = SW + shlt_pkg::TARGET_W;
   localparam int PW  = $clog2(MAX_PASSES + 1);
   localparam int XW  = ((BW > shlt_pkg::LEVEL_W) ? BW : shlt_pkg::LEVEL_W) + 1;
   localparam int HW  = shlt_pkg::HIST_W;

   shlt_pkg::state_type state_ff, state_in;

   logic [1:0]    op_ff, op_in;
   logic [7:0]    lvl_ff, lvl_in;
   logic [7:0]    nb_lat_ff [NEIGHBORS];
   logic [7:0]    req_nb [9];
   logic [BW-1:0] bin_ff, bin_in;
   logic [NKW-1:0] nbk_ff, nbk_in;

   logic          rd_v_ff, rd_v_in;
   logic          rd_last_ff, rd_last_in;
   logic          rd_zero_ff, rd_zero_in;
   logic [BW-1:0] rd_bin_ff, rd_bin_in;

   logic [HW-1:0] acc_ff, acc_in;
   logic [SW-1:0] total_ff, total_in;
   logic [HW-1:0] hi_ff, hi_in;
   logic [HW-1:0] lo_ff, lo_in;
   logic [HW-1:0] t_ff, t_in;
   logic [SW-1:0] capped_ff, capped_in;
   logic [DW-1:0] rhs_ff, rhs_in;
   logic [DW-1:0] tol_ff, tol_in;
   logic [DW-1:0] diff_ff, diff_in;
   logic          gt_ff, gt_in;
   logic [PW-1:0] done_ff, done_in;
   logic [PW-1:0] lim_ff, lim_in;
   logic          conv_ff, conv_in;
   logic          built_ff, built_in;
   logic [HW-1:0] cap_ff, cap_in;
   logic          mask_ff, mask_in;

   logic [6:0]    iter_ff;
   logic [16:0]   tgt_ff;
   logic [15:0]   tolr_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic          rsp_mask_ff, rsp_mask_in;
   logic [19:0]   rsp_thr_ff, rsp_thr_in;
   logic [6:0]    rsp_passes_ff, rsp_passes_in;
   logic          rsp_conv_ff, rsp_conv_in;

   // Weight and histogram memories.
   logic          w_we;
   logic [BW-1:0] w_waddr, w_raddr;
   logic [15:0]   w_rdata;
   logic          h_we;
   logic [HW-1:0] h_wdata;
   logic [BW-1:0] h_raddr;
   logic [HW-1:0] h_rdata;

   // Shared arithmetic.
   logic [XW-1:0] cur_bin, cur_nb, lvl_dist;
   logic [HW-1:0] bin_sum, cap_term;
   logic [16:0]   mul_a;
   logic [DW-1:0] product, lhs;
   logic [HW:0]   mid_sum;
   logic          accept;

   // Phase flags used by the checks at the end of the module.
   logic          sweep_now, rd_phase_now, nbhd_fin_now;

   assign req_nb[0] = req_nb_0;
   assign req_nb[1] = req_nb_1;
   assign req_nb[2] = req_nb_2;
   assign req_nb[3] = req_nb_3;
   assign req_nb[4] = req_nb_4;
   assign req_nb[5] = req_nb_5;
   assign req_nb[6] = req_nb_6;
   assign req_nb[7] = req_nb_7;
   assign req_nb[8] = req_nb_8;

   assign req_ready = (state_ff == shlt_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   shlt_ram #(.DEPTH(BINS), .WIDTH(shlt_pkg::WEIGHT_W)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_weight),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   shlt_ram #(.DEPTH(BINS), .WIDTH(HW)) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (rd_bin_ff),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   // Level distance for the bin and neighbor being issued.
   always_comb begin
      cur_bin  = XW'(bin_ff);
      cur_nb   = XW'(nb_lat_ff[nbk_ff]);
      lvl_dist = (cur_bin > cur_nb) ? (cur_bin - cur_nb) : (cur_nb - cur_bin);
   end

   assign w_we    = accept && (req_op == shlt_pkg::OP_LOAD) && (32'(req_level) < BINS);
   assign w_waddr = BW'(req_level);
   assign w_raddr = lvl_dist[BW-1:0];

   assign bin_sum = acc_ff + (rd_zero_ff ? '0 : HW'(w_rdata));
   assign h_we    = rd_v_ff && rd_last_ff &&
                    ((state_ff == shlt_pkg::ST_BUILD) || (state_ff == shlt_pkg::ST_BUILD_DRAIN));
   assign h_wdata = bin_sum;
   assign h_raddr = (state_ff == shlt_pkg::ST_MASK_RD) ? BW'(lvl_ff) : bin_ff;

   assign cap_term = (h_rdata < t_ff) ? h_rdata : t_ff;
   assign mul_a    = (state_ff == shlt_pkg::ST_MUL_TGT) ? tgt_ff : {1'b0, tolr_ff};
   assign product  = DW'(mul_a) * DW'(total_ff);
   assign lhs      = DW'({capped_ff, 16'b0});

   assign sweep_now    = (state_ff == shlt_pkg::ST_SWEEP);
   assign rd_phase_now = (state_ff == shlt_pkg::ST_BUILD) ||
                         (state_ff == shlt_pkg::ST_BUILD_DRAIN) ||
                         (state_ff == shlt_pkg::ST_SWEEP) ||
                         (state_ff == shlt_pkg::ST_SWEEP_DRAIN);
   assign nbhd_fin_now = (state_ff == shlt_pkg::ST_FIN) && (op_ff == shlt_pkg::OP_NBHD);

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      lvl_in     = lvl_ff;
      bin_in     = bin_ff;
      nbk_in     = nbk_ff;
      rd_v_in    = 1'b0;
      rd_last_in = rd_last_ff;
      rd_zero_in = rd_zero_ff;
      rd_bin_in  = rd_bin_ff;
      acc_in     = acc_ff;
      total_in   = total_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      t_in       = t_ff;
      capped_in  = capped_ff;
      rhs_in     = rhs_ff;
      tol_in     = tol_ff;
      diff_in    = diff_ff;
      gt_in      = gt_ff;
      done_in    = done_ff;
      lim_in     = lim_ff;
      conv_in    = conv_ff;
      built_in   = built_ff;
      cap_in     = cap_ff;
      mask_in    = mask_ff;
      mid_sum    = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_passes_in = rsp_passes_ff;
      rsp_conv_in   = rsp_conv_ff;

      // Data stage of the memory read pipeline.
      if (rd_v_ff) begin
         if ((state_ff == shlt_pkg::ST_BUILD) || (state_ff == shlt_pkg::ST_BUILD_DRAIN)) begin
            if (rd_last_ff) begin
               acc_in   = '0;
               total_in = total_ff + SW'(bin_sum);
               if (bin_sum > hi_ff) begin
                  hi_in = bin_sum;
               end
            end else begin
               acc_in = bin_sum;
            end
         end else begin
            capped_in = capped_ff + SW'(cap_term);
         end
      end

      unique case (state_ff)
         shlt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in  = req_op;
               lvl_in = req_level;
               unique case (req_op)
                  shlt_pkg::OP_LOAD: state_in = shlt_pkg::ST_FIN;
                  shlt_pkg::OP_NBHD: begin
                     bin_in   = '0;
                     nbk_in   = '0;
                     acc_in   = '0;
                     total_in = '0;
                     hi_in    = '0;
                     state_in = shlt_pkg::ST_BUILD;
                  end
                  shlt_pkg::OP_PIXEL: state_in = shlt_pkg::ST_MASK_RD;
                  default: state_in = shlt_pkg::ST_IDLE;
               endcase
            end
         end
         shlt_pkg::ST_BUILD: begin
            rd_v_in    = 1'b1;
            rd_last_in = (32'(nbk_ff) == NEIGHBORS - 1);
            rd_zero_in = (32'(lvl_dist) >= BINS);
            rd_bin_in  = bin_ff;
            if (32'(nbk_ff) == NEIGHBORS - 1) begin
               nbk_in = '0;
               if (32'(bin_ff) == BINS - 1) begin
                  state_in = shlt_pkg::ST_BUILD_DRAIN;
               end else begin
                  bin_in = bin_ff + 1'b1;
               end
            end else begin
               nbk_in = nbk_ff + 1'b1;
            end
         end
         shlt_pkg::ST_BUILD_DRAIN: begin
            built_in = 1'b1;
            state_in = shlt_pkg::ST_MUL_TGT;
         end
         shlt_pkg::ST_MUL_TGT: begin
            rhs_in   = product;
            state_in = shlt_pkg::ST_MUL_TOL;
         end
         shlt_pkg::ST_MUL_TOL: begin
            tol_in    = product;
            t_in      = hi_ff >> 1;
            lo_in     = '0;
            done_in   = '0;
            conv_in   = 1'b0;
            capped_in = '0;
            bin_in    = '0;
            if (32'(iter_ff) > MAX_PASSES) begin
               lim_in = PW'(MAX_PASSES);
            end else begin
               lim_in = PW'(iter_ff);
            end
            state_in = (iter_ff == '0) ? shlt_pkg::ST_FIN : shlt_pkg::ST_SWEEP;
         end
         shlt_pkg::ST_SWEEP: begin
            rd_v_in = 1'b1;
            if (32'(bin_ff) == BINS - 1) begin
               state_in = shlt_pkg::ST_SWEEP_DRAIN;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         shlt_pkg::ST_SWEEP_DRAIN: state_in = shlt_pkg::ST_CHECK;
         shlt_pkg::ST_CHECK: begin
            gt_in    = lhs > rhs_ff;
            diff_in  = (lhs > rhs_ff) ? (lhs - rhs_ff) : (rhs_ff - lhs);
            done_in  = done_ff + 1'b1;
            state_in = shlt_pkg::ST_DECIDE;
         end
         shlt_pkg::ST_DECIDE: begin
            if (diff_ff < tol_ff) begin
               conv_in  = 1'b1;
               state_in = shlt_pkg::ST_FIN;
            end else begin
               if (gt_ff) begin
                  hi_in   = t_ff;
                  mid_sum = {1'b0, lo_ff} + {1'b0, t_ff};
               end else begin
                  lo_in   = t_ff;
                  mid_sum = {1'b0, hi_ff} + {1'b0, t_ff};
               end
               t_in = mid_sum[HW:1];
               if (done_ff == lim_ff) begin
                  state_in = shlt_pkg::ST_FIN;
               end else begin
                  bin_in    = '0;
                  capped_in = '0;
                  state_in  = shlt_pkg::ST_SWEEP;
               end
            end
         end
         shlt_pkg::ST_MASK_RD: state_in = shlt_pkg::ST_MASK_CMP;
         shlt_pkg::ST_MASK_CMP: begin
            // An unbuilt histogram reads as zero.
            mask_in  = (32'(lvl_ff) < BINS) && (!built_ff || (h_rdata <= cap_ff));
            state_in = shlt_pkg::ST_FIN;
         end
         shlt_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = op_ff;
               rsp_mask_in   = 1'b0;
               rsp_thr_in    = '0;
               rsp_passes_in = '0;
               rsp_conv_in   = 1'b0;
               if (op_ff == shlt_pkg::OP_NBHD) begin
                  cap_in        = t_ff;
                  rsp_thr_in    = t_ff;
                  rsp_passes_in = 7'(done_ff);
                  rsp_conv_in   = conv_ff;
               end else if (op_ff == shlt_pkg::OP_PIXEL) begin
                  rsp_mask_in = mask_ff;
               end
               state_in = shlt_pkg::ST_IDLE;
            end
         end
         default: state_in = shlt_pkg::ST_IDLE;
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shlt_pkg::ST_IDLE;
         rd_v_ff      <= 1'b0;
         built_ff     <= 1'b0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= shlt_pkg::ITER_RST;
         tgt_ff       <= shlt_pkg::TARGET_RST;
         tolr_ff      <= shlt_pkg::TOL_RST;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         built_ff     <= built_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               shlt_pkg::CSR_ITER:   iter_ff <= csr_wdata[6:0];
               shlt_pkg::CSR_TARGET: tgt_ff  <= csr_wdata;
               shlt_pkg::CSR_TOL:    tolr_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      lvl_ff     <= lvl_in;
      bin_ff     <= bin_in;
      nbk_ff     <= nbk_in;
      rd_last_ff <= rd_last_in;
      rd_zero_ff <= rd_zero_in;
      rd_bin_ff  <= rd_bin_in;
      acc_ff     <= acc_in;
      total_ff   <= total_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      t_ff       <= t_in;
      capped_ff  <= capped_in;
      rhs_ff     <= rhs_in;
      tol_ff     <= tol_in;
      diff_ff    <= diff_in;
      gt_ff      <= gt_in;
      done_ff    <= done_in;
      lim_ff     <= lim_in;
      conv_ff    <= conv_in;
      mask_ff    <= mask_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_passes_ff <= rsp_passes_in;
      rsp_conv_ff   <= rsp_conv_in;
      if (accept && (req_op == shlt_pkg::OP_NBHD)) begin
         for (int k = 0; k < NEIGHBORS; k++) begin
            nb_lat_ff[k] <= req_nb[k];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_mask_bit  = rsp_mask_ff;
   assign rsp_threshold = rsp_thr_ff;
   assign rsp_passes    = rsp_passes_ff;
   assign rsp_converged = rsp_conv_ff;

   // The bisection bracket always holds the trial threshold.
   `SHLT_ASSERT_IMP(a_bracket, clock, reset, sweep_now, (lo_ff <= t_ff) && (t_ff <= hi_ff))
   // Memory read pipeline runs only in the build and sweep phases.
   `SHLT_ASSERT_NXT(a_rd_phase, clock, reset, rd_v_in, rd_phase_now)
   // Pass count never exceeds the saturated limit.
   `SHLT_ASSERT_IMP(a_pass_limit, clock, reset, nbhd_fin_now, done_ff <= lim_ff)
   // A converged result always ran at least one pass.
   `SHLT_ASSERT_IMP(a_conv_pass, clock, reset, rsp_valid_ff && rsp_conv_ff, rsp_passes_ff != 7'd0)

endmodule

[rtl/shlt_ram.sv]
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shlt_ram #(
   parameter int DEPTH = shlt_pkg::BINS_DEF,
   parameter int WIDTH = shlt_pkg::HIST_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
